// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/mf2d_pkg.sv =====
package mf2d_pkg;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_PAD    = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int CFG_BITS = 11;

    // middle index of a sorted window of side 2r+1
    function automatic int med_index(input logic [1:0] r);
        int res;
        case (r)
            2'd0:    res = 0;
            2'd1:    res = 4;
            2'd2:    res = 12;
            2'd3:    res = 24;
            default: res = 0;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/median_filter_2d.sv =====
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | s_tdata: sample; s_tuser: operation
// m_        | out | m_tvalid/m_tready  | m_tdata: median; m_tlast: last_of_frame
// cfg_      | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// one transaction at a time; when an output is ready, the window is walked with one line store
// read per window sample
// synchronous active-low reset clears the control state; the line store has no reset
// and no clearing pass, it is only read where the current frame wrote it
// a new input is taken while a finished result still waits in the output register;
// a stalled output holds the block in its final step until the result is taken
module median_filter_2d #(
    parameter int MAX_RADIUS  = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [sample]
    input  logic                                   s_tuser,   // [operation]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // [median]
    output logic                                   m_tlast,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_addr,
    input  logic [mf2d_pkg::CFG_BITS-1:0]          cfg_wdata
);
    import mf2d_pkg::*;

    localparam int DW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SB   = SAMPLE_BITS;
    localparam int S    = 2 * MAX_RADIUS + 2;          // rows held in the line store
    localparam int SW   = $clog2(S);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int PRW  = RW + 2;
    localparam int PCW  = CW + 2;
    localparam int RM   = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
    localparam int WIN  = (2 * RM + 1) * (2 * RM + 1);
    localparam int KW   = $clog2(WIN + 1);
    localparam int KIW  = $clog2(WIN);
    localparam int DEPTH = S * (2 ** AW);

    // configuration registers
    logic [1:0]          radius_reg;
    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic                pad_reg;

    // effective frame geometry
    logic [1:0]    rad;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb begin
        rad = (int'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0) w_eff = CW'(1);
        else if (int'(width_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(width_reg);
        if (height_reg == '0) h_eff = RW'(1);
        else if (int'(height_reg) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
        else h_eff = RW'(height_reg);
    end

    state_t state_reg, state_next;

    // positions of the next input and the next output, with their store slots
    logic [RW-1:0] irow_reg, orow_reg;
    logic [CW-1:0] icol_reg, ocol_reg;
    logic [SW-1:0] islot_reg, oslot_reg;

    // window walk
    logic [2:0]    dr_reg, dc_reg;
    logic [SW-1:0] cs_reg;
    logic          p_vld_reg, p_zero_reg;
    logic [KW-1:0] k_reg;
    logic signed [SB-1:0] sorted_reg [WIN];

    // output register
    logic          m_vld_reg;
    logic [SB-1:0] m_med_reg;
    logic          m_last_reg;

    // line store
    logic [SB-1:0] mem [DEPTH];
    logic [SB-1:0] rd_q;
    logic          mem_we;
    logic [SW+AW-1:0] wr_addr, rd_addr;

    logic accept, out_free, last_px, load_out;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = accept && (s_tuser == OP_PIXEL) && (irow_reg < h_eff);
    assign wr_addr  = {islot_reg, icol_reg[AW-1:0]};
    assign out_free = !m_vld_reg || m_tready;
    assign last_px  = (orow_reg == h_eff - RW'(1)) && (ocol_reg == w_eff - CW'(1));
    assign load_out = (state_reg == ST_DONE) && out_free && !p_vld_reg;

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = DW'(m_med_reg);
    assign m_tlast  = m_last_reg;

    // output readiness: bottom-right neighbor of the window has arrived
    logic [RW:0] nr;
    logic [CW:0] nc;
    logic        ready;
    always_comb begin
        nr = {1'b0, orow_reg} + (RW+1)'(rad);
        if (nr > {1'b0, h_eff - RW'(1)}) nr = {1'b0, h_eff - RW'(1)};
        nc = {1'b0, ocol_reg} + (CW+1)'(rad);
        if (nc > {1'b0, w_eff - CW'(1)}) nc = {1'b0, w_eff - CW'(1)};
        ready = ({1'b0, irow_reg} > nr) || (({1'b0, irow_reg} == nr) && ({1'b0, icol_reg} > nc));
    end

    // current window tap
    logic signed [PRW-1:0] fr;
    logic signed [PCW-1:0] fc;
    logic row_oor, col_oor, row_step, win_end, row_end;
    logic [AW-1:0] cc;
    always_comb begin
        fr = $signed({2'b00, orow_reg}) + $signed(PRW'(dr_reg)) - $signed(PRW'(rad));
        fc = $signed({2'b00, ocol_reg}) + $signed(PCW'(dc_reg)) - $signed(PCW'(rad));
        row_oor = (fr < 0) || (fr >= $signed({2'b00, h_eff}));
        col_oor = (fc < 0) || (fc >= $signed({2'b00, w_eff}));
        if (fc < 0) cc = '0;
        else if (fc >= $signed({2'b00, w_eff})) cc = AW'(w_eff - CW'(1));
        else cc = fc[AW-1:0];
        // step to the next slot only when both this row and the next lie in the frame
        row_step = (fr >= 0) && ((fr + PRW'(1)) < $signed({2'b00, h_eff}));
        row_end  = (dc_reg == {rad, 1'b0});
        win_end  = row_end && (dr_reg == {rad, 1'b0});
    end
    assign rd_addr = {cs_reg, cc};

    // sorted insertion of the arriving tap
    logic signed [SB-1:0] x;
    logic [WIN-1:0] gt;
    logic signed [SB-1:0] ins [WIN];
    always_comb begin
        x = p_zero_reg ? '0 : $signed(rd_q);
        for (int i = 0; i < WIN; i++) begin
            gt[i] = (KW'(i) < k_reg) && (sorted_reg[i] > x);
        end
        for (int i = 0; i < WIN; i++) begin
            if ((KW'(i) < k_reg) && !gt[i]) ins[i] = sorted_reg[i];
            else if (i == 0) ins[i] = x;
            else if ((KW'(i - 1) < k_reg) && !gt[i - 1]) ins[i] = x;
            else ins[i] = sorted_reg[i - 1];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CHECK;
            ST_CHECK: state_next = ready ? ST_FETCH : ST_IDLE;
            ST_FETCH: if (win_end) state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // line store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= s_tdata[SB-1:0];
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (p_vld_reg) begin
            for (int i = 0; i < WIN; i++) sorted_reg[i] <= ins[i];
        end
        if (load_out) begin
            m_med_reg  <= sorted_reg[KIW'(med_index(rad))];
            m_last_reg <= last_px;
        end
        if (state_reg == ST_CHECK) begin
            dr_reg <= '0;
            dc_reg <= '0;
            if (orow_reg < RW'(rad)) cs_reg <= '0;
            else if (int'(oslot_reg) >= int'(rad)) cs_reg <= oslot_reg - SW'(rad);
            else cs_reg <= SW'(int'(oslot_reg) + S - int'(rad));
        end else if (state_reg == ST_FETCH) begin
            p_zero_reg <= !pad_reg && (row_oor || col_oor);
            if (row_end) begin
                dc_reg <= '0;
                dr_reg <= dr_reg + 3'd1;
                if (row_step) cs_reg <= (int'(cs_reg) == S - 1) ? '0 : cs_reg + SW'(1);
            end else begin
                dc_reg <= dc_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            radius_reg <= 2'd1;
            width_reg  <= CFG_BITS'(1024);
            height_reg <= CFG_BITS'(1024);
            pad_reg    <= 1'b0;
            irow_reg   <= '0;
            icol_reg   <= '0;
            islot_reg  <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            oslot_reg  <= '0;
            p_vld_reg  <= 1'b0;
            k_reg      <= '0;
            m_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_vld_reg <= (state_reg == ST_FETCH);
            if (state_reg == ST_CHECK) k_reg <= '0;
            else if (p_vld_reg) k_reg <= k_reg + KW'(1);

            if (load_out) m_vld_reg <= 1'b1;
            else if (m_tready) m_vld_reg <= 1'b0;

            if (cfg_we) begin
                // any register write abandons the frame
                irow_reg  <= '0;
                icol_reg  <= '0;
                islot_reg <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
                oslot_reg <= '0;
            end else if (mem_we) begin
                if (icol_reg == w_eff - CW'(1)) begin
                    icol_reg  <= '0;
                    irow_reg  <= irow_reg + RW'(1);
                    islot_reg <= (int'(islot_reg) == S - 1) ? '0 : islot_reg + SW'(1);
                end else begin
                    icol_reg <= icol_reg + CW'(1);
                end
            end else if (load_out) begin
                if (last_px) begin
                    // frame complete: start over
                    irow_reg  <= '0;
                    icol_reg  <= '0;
                    islot_reg <= '0;
                    orow_reg  <= '0;
                    ocol_reg  <= '0;
                    oslot_reg <= '0;
                end else if (ocol_reg == w_eff - CW'(1)) begin
                    ocol_reg  <= '0;
                    orow_reg  <= orow_reg + RW'(1);
                    oslot_reg <= (int'(oslot_reg) == S - 1) ? '0 : oslot_reg + SW'(1);
                end else begin
                    ocol_reg <= ocol_reg + CW'(1);
                end
            end

            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RADIUS: radius_reg <= cfg_wdata[1:0];
                    CFG_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_reg <= cfg_wdata;
                    CFG_PAD:    pad_reg    <= cfg_wdata[0];
                    default:    pad_reg    <= pad_reg;
                endcase
            end
        end
    end

    `include "assert_macros.svh"

    // line store is written only when a new sample is taken
    `ASSERT_CLK(a_we_idle, mem_we |-> (state_reg == ST_IDLE), "line store write outside idle")
    // a tap arrives only in the cycle after a fetch step issued it
    `ASSERT_CLK(a_tap_follows, p_vld_reg |-> $past(state_reg == ST_FETCH), "stray window tap")
    // a result is loaded only with the whole window sorted
    `ASSERT_CLK(a_full_window, load_out |-> (k_reg == KW'((2 * rad + 1) * (2 * rad + 1))),
                "median taken from a partial window")
    // sorter never overfills
    `ASSERT_CLK(a_k_bound, k_reg <= KW'(WIN), "window count past capacity")

endmodule

// ===== tb/sv/median_filter_2d_test.sv =====
`timescale 1ns / 1ps

module median_filter_2d_test;
    import mf2d_pkg::*;

    localparam int MAX_R     = 3;
    localparam int MAX_W     = 1024;
    localparam int MAX_H     = 1024;
    localparam int SLOTS     = 2 * MAX_R + 2;
    localparam int WATCHDOG  = 200000;
    localparam int SETTLE    = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [sample]
    logic        s_tuser = 1'b0;   // [operation]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [median]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [10:0] cfg_wdata = '0;

    always #1 aclk = ~aclk;

    median_filter_2d u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic [15:0] median;
        logic        last;
    } pixel_out_t;

    // predictor state: registers and frame positions
    logic [1:0]  radius_q;
    logic [10:0] width_q, height_q;
    logic        pad_q;
    logic signed [15:0] rows_q [SLOTS * MAX_W];
    int in_row, in_col, out_row, out_col;

    pixel_out_t medians_due[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;       // no idling in the last part of the run
    bit  hold_rx = 1'b0;    // long receiver hold-off request

    function automatic int frame_w();
        if (width_q == 0) return 1;
        return (width_q > MAX_W) ? MAX_W : int'(width_q);
    endfunction

    function automatic int frame_h();
        if (height_q == 0) return 1;
        return (height_q > MAX_H) ? MAX_H : int'(height_q);
    endfunction

    function automatic logic signed [15:0] window_pick(int r, int c, int w, int h);
        if (r < 0 || r >= h || c < 0 || c >= w) begin
            if (!pad_q) return 16'sd0;
            r = (r < 0) ? 0 : ((r >= h) ? h - 1 : r);
            c = (c < 0) ? 0 : ((c >= w) ? w - 1 : c);
        end
        return rows_q[(r % SLOTS) * MAX_W + c];
    endfunction

    // advance the filter model by one accepted transaction
    function automatic void predict_median(logic op, logic signed [15:0] smp);
        int w, h, rad, nr, nc, n, k, m;
        logic signed [15:0] win [49];
        logic signed [15:0] key;
        pixel_out_t res;
        w = frame_w();
        h = frame_h();
        rad = radius_q;
        if (in_col >= w) in_col = 0;
        if (in_row > h) in_row = h;
        if (out_col >= w) out_col = 0;
        if (out_row >= h) out_row = 0;
        if (op == OP_PIXEL && in_row < h) begin
            rows_q[(in_row % SLOTS) * MAX_W + in_col] = smp;
            in_col++;
            if (in_col == w) begin
                in_col = 0;
                in_row++;
            end
        end
        nr = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
        nc = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
        if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
        n = 0;
        for (int dr = -rad; dr <= rad; dr++)
            for (int dc = -rad; dc <= rad; dc++) begin
                win[n] = window_pick(out_row + dr, out_col + dc, w, h);
                n++;
            end
        for (k = 1; k < n; k++) begin
            key = win[k];
            m = k;
            while (m > 0 && win[m - 1] > key) begin
                win[m] = win[m - 1];
                m--;
            end
            win[m] = key;
        end
        res.median = win[n / 2];
        res.last = (out_row == h - 1 && out_col == w - 1);
        medians_due.push_back(res);
        if (res.last) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else begin
            out_col++;
            if (out_col == w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // result checker against the oldest expected median
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (medians_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result median=%0d last=%0b",
                             $signed(m_tdata), m_tlast);
            end else begin
                pixel_out_t exp_r;
                exp_r = medians_due.pop_front();
                if (m_tdata !== exp_r.median || m_tlast !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("median mismatch: expected %0d/%0b got %0d/%0b",
                                 $signed(exp_r.median), exp_r.last,
                                 $signed(m_tdata), m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_rx = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // drives one register write; the caller drops cfg_we after the last one
    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_RADIUS: radius_q = val[1:0];
            CFG_WIDTH:  width_q = val;
            CFG_HEIGHT: height_q = val;
            default:    pad_q = val[0];
        endcase
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endtask

    // one transaction; optional sender gap before it
    task automatic send_item(logic op, logic [15:0] smp);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= smp;
        @(posedge aclk iff s_tready);
        predict_median(op, smp);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (medians_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic setup_frame(logic [1:0] r, logic [10:0] w, logic [10:0] h, logic p);
        wait_drained();
        write_reg(CFG_RADIUS, {9'd0, r});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PAD, {10'd0, p});
        cfg_we <= 1'b0;
    endtask

    // whole frame of random pixels, then drain ticks until it completes
    task automatic random_frame(int w, int h);
        int guard;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(OP_DRAIN, 16'($urandom));
            send_item(OP_PIXEL, ($urandom_range(0, 3) == 0) ?
                      16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff) : 16'($urandom));
        end
        guard = 0;
        while ((in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0) && guard < 200) begin
            send_item(OP_DRAIN, 16'($urandom));
            guard++;
        end
    endtask

    typedef struct {
        logic        op;
        logic [15:0] smp;
        bit          known;
        pixel_out_t  exp_r;
    } stim_row_t;

    // directed table: 3x1 frame, radius 0, so each median is the sample itself
    stim_row_t directed[$] = '{
        '{OP_DRAIN, 16'h1234, 1'b0, '{16'h0000, 1'b0}},
        '{OP_PIXEL, 16'h8000, 1'b1, '{16'h8000, 1'b0}},
        '{OP_PIXEL, 16'h7fff, 1'b1, '{16'h7fff, 1'b0}},
        '{OP_PIXEL, 16'hffff, 1'b1, '{16'hffff, 1'b1}},
        '{OP_DRAIN, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
        '{OP_PIXEL, 16'h5555, 1'b1, '{16'h5555, 1'b0}},
        '{OP_PIXEL, 16'haaaa, 1'b1, '{16'haaaa, 1'b0}},
        '{OP_PIXEL, 16'h0000, 1'b1, '{16'h0000, 1'b1}}
    };

    initial begin
        int sent;
        radius_q = 2'd1; width_q = 11'd1024; height_q = 11'd1024; pad_q = 1'b0;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        setup_frame(2'd0, 11'd3, 11'd1, 1'b0);
        foreach (directed[i]) begin
            send_item(directed[i].op, directed[i].smp);
            if (directed[i].known) begin
                if (medians_due.size() == 0) begin
                    mismatches++;
                    $display("directed row %0d: no result predicted", i);
                end else if (medians_due[$] != directed[i].exp_r) begin
                    mismatches++;
                    $display("directed row %0d: table and predictor disagree", i);
                end
            end
        end

        // zero sizes taken as a 1x1 frame, 3x3 window both pads
        setup_frame(2'd1, 11'd0, 11'd0, 1'b1);
        send_item(OP_PIXEL, 16'h4321);
        setup_frame(2'd1, 11'd4, 11'd3, 1'b0);
        random_frame(4, 3);
        setup_frame(2'd1, 11'd4, 11'd3, 1'b1);
        random_frame(4, 3);
        // width above the maximum saturates; abandon the frame with a write
        setup_frame(2'd3, 11'd2047, 11'd2047, 1'b0);
        for (int i = 0; i < 20; i++) send_item(OP_PIXEL, 16'($urandom));

        // receiver hold-off while the sender keeps offering
        setup_frame(2'd0, 11'd64, 11'd2, 1'b0);
        hold_rx = 1'b1;
        random_frame(64, 2);

        // random frames across all radii and pads, mostly small
        sent = 0;
        while (sent < 2000) begin
            int w, h;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
            h = $urandom_range(1, 8);
            if (sent > 1600) calm = 1'b1;
            setup_frame(2'($urandom_range(0, 3)), 11'(w), 11'(h), 1'($urandom_range(0, 1)));
            random_frame(w, h);
            sent += w * h;
        end

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mf2d_pkg.sv
sv/median_filter_2d.sv
tb/sv/median_filter_2d_test.sv
